[rtl/lcpi_pkg.sv]
package lcpi_pkg;

  // Default parameter values
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int SUM_BITS_DEF    = 32;

  // Fixed field widths
  localparam int NUM_CH        = 3;
  localparam int BRIGHT_BITS   = 8;
  localparam int GAIN_BITS     = 16;
  localparam int DUTY_BITS     = 16;
  localparam int DEAD_BITS     = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Register reset values
  localparam logic [GAIN_BITS-1:0] GAIN_P_RST = 16'd5000;
  localparam logic [GAIN_BITS-1:0] GAIN_I_RST = 16'd2;
  localparam logic [GAIN_BITS-1:0] GAIN_D_RST = 16'd0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BRIGHT_RED   = 3'd0,
    REG_BRIGHT_GREEN = 3'd1,
    REG_BRIGHT_BLUE  = 3'd2,
    REG_PERIOD       = 3'd3,
    REG_DEAD         = 3'd4,
    REG_GAIN_P       = 3'd5,
    REG_GAIN_I       = 3'd6,
    REG_GAIN_D       = 3'd7
  } cfg_reg_t;

  // Brightness to target ADC code
  localparam int CUR_NUM  = 750;
  localparam int BR_DIV   = 256;
  localparam int ADC_FULL = 4096;
  localparam int ADC_MV   = 3300;
  localparam int TGT_BITS = 10;

  typedef logic [(1 << BRIGHT_BITS)-1:0][TGT_BITS-1:0] tgt_tab_t;

  function automatic tgt_tab_t build_tgt_tab();
    tgt_tab_t tab;
    int unsigned t;
    for (int b = 0; b < (1 << BRIGHT_BITS); b++) begin
      t = (CUR_NUM * b) / BR_DIV;
      tab[b] = TGT_BITS'((t * ADC_FULL) / ADC_MV);
    end
    return tab;
  endfunction

  localparam tgt_tab_t TARGET_TAB = build_tgt_tab();

  // Output scaling: 100000 = 3125 * 32
  localparam int SCALE_SHIFT = 5;
  localparam int SCALE_ODD   = 3125;
  localparam int PID_SCALE   = SCALE_ODD << SCALE_SHIFT;

  // Integral term limit, 2^61
  localparam int ILIM_LOG = 61;

  // Quotient saturates at +-2^QLIM_LOG, well past any duty value
  localparam int QLIM_LOG = 17;
  localparam logic [63:0] X_LIM = 64'(PID_SCALE) << QLIM_LOG;
  localparam int Y_BITS   = $clog2(2 * X_LIM + 1);
  localparam int N_BITS   = Y_BITS - SCALE_SHIFT;
  localparam int RCP_SHIFT = N_BITS + $clog2(SCALE_ODD);
  localparam longint unsigned RCP_MULT_L =
    ((64'd1 << RCP_SHIFT) + SCALE_ODD - 1) / SCALE_ODD;
  localparam int RCP_BITS = $clog2(RCP_MULT_L + 1);
  localparam logic [RCP_BITS-1:0] RCP_MULT = RCP_BITS'(RCP_MULT_L);
  localparam int PROD_BITS = N_BITS + RCP_BITS;
  localparam int QO_BITS   = QLIM_LOG + 2;

  // Pipeline control
  localparam int NUM_STG = 5;

  typedef struct packed {
    logic [NUM_STG-1:0] ld;
    logic               out_ld;
  } pipe_ctl_t;

endpackage

[rtl/lcpi_ctrl.sv]
module lcpi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lcpi_pkg::pipe_ctl_t ctl
);
  import lcpi_pkg::*;

  logic [NUM_STG-1:0] v_r, v_nxt;
  logic               ov_r, ov_nxt;
  logic [NUM_STG:0]   rdy;

  // A stage takes a new request when it is empty or its content moves on
  always_comb begin
    rdy[NUM_STG] = !ov_r || out_ready;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ctl.ld[0] = rdy[0] && in_valid;
    v_nxt[0]  = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      ctl.ld[k] = rdy[k] && v_r[k-1];
      v_nxt[k]  = rdy[k] ? v_r[k-1] : v_r[k];
    end
    ctl.out_ld = rdy[NUM_STG] && v_r[NUM_STG-1];
    ov_nxt     = rdy[NUM_STG] ? v_r[NUM_STG-1] : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      v_r  <= v_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = ov_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&v_r) && ov_r && !out_ready))
    else $error("input blocked while the pipeline has a free stage");

endmodule

[rtl/lcpi_lane.sv]
module lcpi_lane #(
  parameter int SAMPLE_BITS = lcpi_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = lcpi_pkg::SUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcpi_pkg::pipe_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [lcpi_pkg::TGT_BITS-1:0] tgt_i,
  input  logic [lcpi_pkg::GAIN_BITS-1:0] kp_i,
  input  logic [lcpi_pkg::GAIN_BITS-1:0] ki_i,
  input  logic [lcpi_pkg::GAIN_BITS-1:0] kd_i,
  output logic [lcpi_pkg::QO_BITS-1:0]  qo_o,
  output logic                          tz_o
);
  import lcpi_pkg::*;

  localparam int ERR_BITS = ((SAMPLE_BITS > TGT_BITS) ? SAMPLE_BITS : TGT_BITS) + 1;
  localparam int SW       = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;
  localparam int P_BITS   = GAIN_BITS + 1 + ERR_BITS;
  localparam int D_BITS   = P_BITS + 1;
  localparam int I_BITS   = GAIN_BITS + 1 + SUM_BITS;
  localparam int XW       = ((I_BITS > ILIM_LOG + 2) ? I_BITS : ILIM_LOG + 2) + 2;

  localparam logic signed [SW-1:0] SUM_MAX = SW'({1'b0, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [XW-1:0] ILIM =
    {{(XW-ILIM_LOG-1){1'b0}}, 1'b1, {ILIM_LOG{1'b0}}};
  localparam logic signed [XW-1:0] XLIM = XW'(X_LIM);

  // Stage 1: error, saturating sum, error difference
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic signed [ERR_BITS-1:0] lerr_r, err;
  logic signed [SW-1:0]       sum_w;
  logic signed [ERR_BITS:0]   diff, diff1_r;
  logic                       tz1_r;

  always_comb begin
    err   = $signed({{(ERR_BITS-TGT_BITS){1'b0}}, tgt_i})
          - $signed({{(ERR_BITS-SAMPLE_BITS){1'b0}}, sample_i});
    sum_w = SW'(sum_r) + SW'(err);
    if (sum_w > SUM_MAX) begin
      sum_nxt = SUM_MAX[SUM_BITS-1:0];
    end else if (sum_w < SUM_MIN) begin
      sum_nxt = SUM_MIN[SUM_BITS-1:0];
    end else begin
      sum_nxt = sum_w[SUM_BITS-1:0];
    end
    diff = (ERR_BITS+1)'(err) - (ERR_BITS+1)'(lerr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      lerr_r <= '0;
    end else if (ctl.ld[0]) begin
      sum_r  <= sum_nxt;
      lerr_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      diff1_r <= diff;
      tz1_r   <= (tgt_i == '0);
    end
  end

  // Stage 2: gain products (sum_r and lerr_r belong to the request in stage 1)
  logic signed [P_BITS-1:0] pp2_r;
  logic signed [I_BITS-1:0] ip2_r;
  logic signed [D_BITS-1:0] dp2_r;
  logic                     tz2_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      pp2_r <= P_BITS'($signed({1'b0, kp_i})) * P_BITS'(lerr_r);
      ip2_r <= I_BITS'($signed({1'b0, ki_i})) * I_BITS'(sum_r);
      dp2_r <= D_BITS'($signed({1'b0, kd_i})) * D_BITS'(diff1_r);
      tz2_r <= tz1_r;
    end
  end

  // Stage 3: limit integral term, add terms
  logic signed [XW-1:0] ip_x, isat, x3_r;
  logic                 tz3_r;

  always_comb begin
    ip_x = XW'(ip2_r);
    if (ip_x > ILIM) begin
      isat = ILIM;
    end else if (ip_x < -ILIM) begin
      isat = -ILIM;
    end else begin
      isat = ip_x;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      x3_r  <= isat + XW'(pp2_r) + XW'(dp2_r);
      tz3_r <= tz2_r;
    end
  end

  // Stage 4: saturate, offset to non-negative, drop the power-of-two factor
  logic signed [XW-1:0] xc, y;
  logic [N_BITS-1:0]    n4_r;
  logic                 tz4_r;

  always_comb begin
    if (x3_r > XLIM) begin
      xc = XLIM;
    end else if (x3_r < -XLIM) begin
      xc = -XLIM;
    end else begin
      xc = x3_r;
    end
    y = xc + XLIM;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      n4_r  <= y[SCALE_SHIFT +: N_BITS];
      tz4_r <= tz3_r;
    end
  end

  // Stage 5: divide by the odd factor through a reciprocal multiply
  logic [PROD_BITS-1:0] prod;
  logic [QO_BITS-1:0]   qo_r;
  logic                 tz5_r;

  assign prod = PROD_BITS'(n4_r) * PROD_BITS'(RCP_MULT);

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      qo_r  <= prod[RCP_SHIFT +: QO_BITS];
      tz5_r <= tz4_r;
    end
  end

  assign qo_o = qo_r;
  assign tz_o = tz5_r;

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.ld[0] |=> $stable(sum_r) && $stable(lerr_r))
    else $error("channel state changed without an accepted request");

endmodule

[rtl/lcpi_merge.sv]
module lcpi_merge (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  lcpi_pkg::pipe_ctl_t                               ctl,
  input  logic [lcpi_pkg::NUM_CH-1:0][lcpi_pkg::QO_BITS-1:0] qo_i,
  input  logic [lcpi_pkg::NUM_CH-1:0]                       tz_i,
  input  logic [lcpi_pkg::DUTY_BITS-1:0]                    period_i,
  input  logic [lcpi_pkg::DEAD_BITS-1:0]                    dead_i,
  output logic [lcpi_pkg::NUM_CH-1:0][lcpi_pkg::DUTY_BITS-1:0] duty_o
);
  import lcpi_pkg::*;

  localparam int M_BITS = QO_BITS + 2;
  localparam logic signed [M_BITS-1:0] QOFF = M_BITS'(1 << QLIM_LOG);

  logic [NUM_CH-1:0][DUTY_BITS-1:0] duty_r, duty_nxt;
  logic [DUTY_BITS-1:0]             win_end;
  logic signed [M_BITS-1:0]         end_e, dead_e;
  logic signed [M_BITS-1:0]         m [NUM_CH];
  logic signed [M_BITS-1:0]         m_hi [NUM_CH];
  logic signed [M_BITS-1:0]         m_lo [NUM_CH];

  // The duty register doubles as the previous duty of each channel
  always_comb begin
    win_end = period_i - DUTY_BITS'(dead_i);
    end_e   = $signed(M_BITS'(win_end));
    dead_e  = $signed(M_BITS'(dead_i));
    for (int c = 0; c < NUM_CH; c++) begin
      m[c]    = $signed(M_BITS'(duty_r[c])) + $signed(M_BITS'(qo_i[c])) - QOFF;
      m_hi[c] = (m[c] > end_e) ? end_e : m[c];
      m_lo[c] = (m_hi[c] < dead_e) ? dead_e : m_hi[c];
      duty_nxt[c] = tz_i[c] ? '0 : m_lo[c][DUTY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
    end else if (ctl.out_ld) begin
      duty_r <= duty_nxt;
    end
  end

  assign duty_o = duty_r;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_chk
    a_duty_floor: assert property (@(posedge clk) disable iff (!rst_n)
      ctl.out_ld |=> (duty_r[g] == '0) || (duty_r[g] >= DUTY_BITS'($past(dead_i))))
      else $error("duty below dead time");
  end

endmodule

[rtl/three_channel_led_current_pi_loop.sv]
// Three-channel LED current regulator, PID in velocity form with a clamped output.
//
// Input channel: one request carries the red, green and blue ADC samples of
// one conversion (in_sample_*), handshake in_valid / in_ready. Result channel:
// three PWM compare values (out_duty_*), handshake out_valid / out_ready.
// Configuration: cfg_we writes cfg_data into register cfg_index (brightness
// red/green/blue, period, dead time, P, I and D gains); write only while idle.
//
// The request enters the first of five lane stages (error and sum, gain
// multipliers, term add, saturation, reciprocal multiply for the division by
// 100000) at the accepting edge and then moves on to the output register, where
// the previous duty closes its loop with one add and two compares. One request
// is taken every cycle while the pipeline has a free stage.
// When the receiver stalls, the output holds and the stages behind it keep
// filling; in_ready drops only once every stage holds a request.
// Reset clears the error sums, previous errors, duties and settings (gains to
// defaults, brightness to zero), not the stage data. No clearing pass is needed.
module three_channel_led_current_pi_loop #(
  parameter int SAMPLE_BITS = lcpi_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = lcpi_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_sample_red,
  input  logic [SAMPLE_BITS-1:0]            in_sample_green,
  input  logic [SAMPLE_BITS-1:0]            in_sample_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lcpi_pkg::DUTY_BITS-1:0]    out_duty_red,
  output logic [lcpi_pkg::DUTY_BITS-1:0]    out_duty_green,
  output logic [lcpi_pkg::DUTY_BITS-1:0]    out_duty_blue,
  input  logic                              cfg_we,
  input  logic [lcpi_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lcpi_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import lcpi_pkg::*;

  // Configuration. Brightness is kept as the target ADC code it selects,
  // looked up once at write time.
  logic [NUM_CH-1:0][TGT_BITS-1:0] tgt_r;
  logic [DUTY_BITS-1:0]            period_r;
  logic [DEAD_BITS-1:0]            dead_r;
  logic [GAIN_BITS-1:0]            kp_r, ki_r, kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r    <= '0;
      period_r <= '0;
      dead_r   <= '0;
      kp_r     <= GAIN_P_RST;
      ki_r     <= GAIN_I_RST;
      kd_r     <= GAIN_D_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BRIGHT_RED:   tgt_r[CH_RED]   <= TARGET_TAB[cfg_data[BRIGHT_BITS-1:0]];
        REG_BRIGHT_GREEN: tgt_r[CH_GREEN] <= TARGET_TAB[cfg_data[BRIGHT_BITS-1:0]];
        REG_BRIGHT_BLUE:  tgt_r[CH_BLUE]  <= TARGET_TAB[cfg_data[BRIGHT_BITS-1:0]];
        REG_PERIOD:       period_r <= cfg_data[DUTY_BITS-1:0];
        REG_DEAD:         dead_r   <= cfg_data[DEAD_BITS-1:0];
        REG_GAIN_P:       kp_r     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_I:       ki_r     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_D:       kd_r     <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage advance for all lanes at once
  pipe_ctl_t ctl;

  lcpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // One lane per color
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] smp;
  logic [NUM_CH-1:0][QO_BITS-1:0]     qo;
  logic [NUM_CH-1:0]                  tz;

  assign smp[CH_RED]   = in_sample_red;
  assign smp[CH_GREEN] = in_sample_green;
  assign smp[CH_BLUE]  = in_sample_blue;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    lcpi_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sample_i (smp[g]),
      .tgt_i    (tgt_r[g]),
      .kp_i     (kp_r),
      .ki_i     (ki_r),
      .kd_i     (kd_r),
      .qo_o     (qo[g]),
      .tz_o     (tz[g])
    );
  end

  // Add each lane's step to its previous duty, clamp (zero for a zero target), and register the result
  logic [NUM_CH-1:0][DUTY_BITS-1:0] duty;

  lcpi_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .qo_i     (qo),
    .tz_i     (tz),
    .period_i (period_r),
    .dead_i   (dead_r),
    .duty_o   (duty)
  );

  assign out_duty_red   = duty[CH_RED];
  assign out_duty_green = duty[CH_GREEN];
  assign out_duty_blue  = duty[CH_BLUE];

endmodule

[dv/led_pi_duty_checker.sv]
`timescale 1ns / 1ps

module led_pi_duty_checker #(
  parameter int SAMPLE_BITS = lcpi_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = lcpi_pkg::SUM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             in_sample_red,
  input  logic [SAMPLE_BITS-1:0]             in_sample_green,
  input  logic [SAMPLE_BITS-1:0]             in_sample_blue,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [lcpi_pkg::DUTY_BITS-1:0]     out_duty_red,
  input  logic [lcpi_pkg::DUTY_BITS-1:0]     out_duty_green,
  input  logic [lcpi_pkg::DUTY_BITS-1:0]     out_duty_blue,
  input  logic                               cfg_we,
  input  logic [lcpi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lcpi_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                 mismatch_count,
  output int                                 pending_count
);
  import lcpi_pkg::*;

  localparam longint ACC_MAX     = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint ACC_MIN     = -ACC_MAX - 1;
  localparam longint ITERM_LIM   = longint'(1) << 61;
  localparam longint DUTY_SCALE  = 100000;
  localparam int     PRINT_LIMIT = 40;

  typedef logic [NUM_CH-1:0][DUTY_BITS-1:0] duty_set_t;

  // Shadow registers
  logic [BRIGHT_BITS-1:0] bright [NUM_CH];
  logic [DUTY_BITS-1:0]   period;
  logic [DEAD_BITS-1:0]   dead;
  logic [GAIN_BITS-1:0]   kp, ki, kd;

  // Loop state per channel
  longint                 err_acc   [NUM_CH];
  longint                 last_err  [NUM_CH];
  logic [DUTY_BITS-1:0]   prev_duty [NUM_CH];

  duty_set_t duty_expected [$];
  int        results_seen;
  string     ch_name [NUM_CH] = '{"red", "green", "blue"};

  task automatic report_mismatch(input string msg);
    // cap the log, keep counting
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // One channel of the velocity-form loop; updates that channel's state.
  function automatic logic [DUTY_BITS-1:0] next_duty(input int ch,
                                                     input logic [SAMPLE_BITS-1:0] smp);
    longint target, err, acc, iterm, num, m, lim;
    logic [DUTY_BITS-1:0] win_end;
    target = (longint'(750) * longint'(bright[ch])) / 256;
    target = (target * 4096) / 3300;
    err = target - longint'(smp);
    acc = err_acc[ch] + err;
    if (acc > ACC_MAX) acc = ACC_MAX;
    if (acc < ACC_MIN) acc = ACC_MIN;
    err_acc[ch] = acc;
    if (ki == '0) begin
      iterm = 0;
    end else begin
      lim = ITERM_LIM / longint'(ki);
      if (acc > lim) iterm = ITERM_LIM;
      else if (acc < -lim) iterm = -ITERM_LIM;
      else iterm = longint'(ki) * acc;
    end
    num = longint'(kp) * err + iterm + longint'(kd) * (err - last_err[ch])
        + longint'(prev_duty[ch]) * DUTY_SCALE;
    m = num / DUTY_SCALE;
    win_end = period - {{(DUTY_BITS - DEAD_BITS){1'b0}}, dead};
    if (m > longint'(win_end)) m = longint'(win_end);
    if (m < longint'(dead)) m = longint'(dead);
    if (target == 0) m = 0;
    last_err[ch]  = err;
    prev_duty[ch] = m[DUTY_BITS-1:0];
    return m[DUTY_BITS-1:0];
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    results_seen   = 0;
  end

  always @(posedge clk) begin
    duty_set_t got, want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        bright[c]    = '0;
        err_acc[c]   = 0;
        last_err[c]  = 0;
        prev_duty[c] = '0;
      end
      period = '0;
      dead   = '0;
      kp     = GAIN_P_RST;
      ki     = GAIN_I_RST;
      kd     = GAIN_D_RST;
      duty_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_BRIGHT_RED:   bright[CH_RED]   = cfg_data[BRIGHT_BITS-1:0];
          REG_BRIGHT_GREEN: bright[CH_GREEN] = cfg_data[BRIGHT_BITS-1:0];
          REG_BRIGHT_BLUE:  bright[CH_BLUE]  = cfg_data[BRIGHT_BITS-1:0];
          REG_PERIOD:       period = cfg_data;
          REG_DEAD:         dead   = cfg_data[DEAD_BITS-1:0];
          REG_GAIN_P:       kp     = cfg_data;
          REG_GAIN_I:       ki     = cfg_data;
          REG_GAIN_D:       kd     = cfg_data;
          default: ;
        endcase
      end
      // compare before predicting, so a result never meets its own request
      if (out_valid && out_ready) begin
        got[CH_RED]   = out_duty_red;
        got[CH_GREEN] = out_duty_green;
        got[CH_BLUE]  = out_duty_blue;
        if (duty_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = duty_expected.pop_front();
          for (int c = 0; c < NUM_CH; c++)
            if (got[c] !== want[c])
              report_mismatch($sformatf("result %0d %s duty %0d, expected %0d",
                                        results_seen, ch_name[c], got[c], want[c]));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        want[CH_RED]   = next_duty(CH_RED,   in_sample_red);
        want[CH_GREEN] = next_duty(CH_GREEN, in_sample_green);
        want[CH_BLUE]  = next_duty(CH_BLUE,  in_sample_blue);
        duty_expected.push_back(want);
      end
    end
    pending_count = duty_expected.size();
  end

endmodule

[dv/three_channel_led_current_pi_loop_test.sv]
`timescale 1ns / 1ps

module three_channel_led_current_pi_loop_test;
  import lcpi_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam logic [SB-1:0] SMP_MAX = {SB{1'b1}};
  // Random part: phases with fresh register settings each
  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES    = 12;

  logic          clk;
  logic          rst_n           = 1'b0;
  logic          in_valid        = 1'b0;
  logic          in_ready;
  logic [SB-1:0] in_sample_red   = '0;
  logic [SB-1:0] in_sample_green = '0;
  logic [SB-1:0] in_sample_blue  = '0;
  logic          out_valid;
  logic          out_ready       = 1'b0;
  logic [DUTY_BITS-1:0]     out_duty_red, out_duty_green, out_duty_blue;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  int mismatch_count, pending_count;
  int sender_idle_pct   = 28;
  int receiver_idle_pct = 49;
  int items_sent        = 0;
  int settings_used     = 0;

  three_channel_led_current_pi_loop u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_red   (in_sample_red),
    .in_sample_green (in_sample_green),
    .in_sample_blue  (in_sample_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_duty_red    (out_duty_red),
    .out_duty_green  (out_duty_green),
    .out_duty_blue   (out_duty_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  led_pi_duty_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_red   (in_sample_red),
    .in_sample_green (in_sample_green),
    .in_sample_blue  (in_sample_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_duty_red    (out_duty_red),
    .out_duty_green  (out_duty_green),
    .out_duty_blue   (out_duty_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at random according to the current idle mix.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2ms;
    $display("three_channel_led_current_pi_loop test failed");
    $finish;
  end

  // Offer one request; return at the edge that accepts it. Valid stays high
  // back to back when no idle cycle is drawn.
  task automatic send_triplet(input logic [SB-1:0] r, input logic [SB-1:0] g,
                              input logic [SB-1:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_red   <= r;
    in_sample_green <= g;
    in_sample_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back, then
  // let the pipeline settle before touching registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back, then release the write enable.
  task automatic program_regs(input logic [7:0] br_r, input logic [7:0] br_g,
                              input logic [7:0] br_b, input logic [15:0] per,
                              input logic [11:0] dt, input logic [15:0] gp,
                              input logic [15:0] gi, input logic [15:0] gd);
    cfg_reg_t             idx [8];
    logic [CFG_DATA_BITS-1:0] val [8];
    idx = '{REG_BRIGHT_RED, REG_BRIGHT_GREEN, REG_BRIGHT_BLUE, REG_PERIOD,
            REG_DEAD, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D};
    val = '{{8'd0, br_r}, {8'd0, br_g}, {8'd0, br_b}, per, {4'd0, dt}, gp, gi, gd};
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Mostly a typical spread, with zero and the top of range mixed in.
  function automatic logic [15:0] pick_reg(input logic [15:0] top, input logic [15:0] typ);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return top;
    return 16'($urandom_range(0, typ));
  endfunction

  // Half full scale, half near the targets the brightness range can ask for.
  function automatic logic [SB-1:0] pick_sample();
    if ($urandom_range(0, 1)) return SB'($urandom_range(0, SMP_MAX));
    return SB'($urandom_range(0, 1023));
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero brightness forces every duty to zero, while the
    // loop state still moves.
    send_triplet('0, '0, '0);
    send_triplet(SMP_MAX, SMP_MAX, SMP_MAX);
    send_triplet(12'hAAA, 12'h555, 12'hFFF);

    // Full window, default gains; drive the duty up, down, then hold at target.
    wait_drained();
    program_regs(8'd255, 8'd128, 8'd1, 16'hFFFF, 12'd0, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
    repeat (3) send_triplet('0, '0, '0);
    repeat (2) send_triplet(SMP_MAX, SMP_MAX, SMP_MAX);
    send_triplet(12'd927, 12'd465, 12'd2);

    // Inverted window (dead past the window end), all gains at maximum.
    wait_drained();
    program_regs(8'd255, 8'd255, 8'd255, 16'd100, 12'd80, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_triplet('0, SMP_MAX, '0);
    send_triplet(SMP_MAX, '0, SMP_MAX);
    send_triplet(12'd500, 12'd500, 12'd500);

    // Empty window: period and dead both zero.
    wait_drained();
    program_regs(8'd200, 8'd1, 8'd0, 16'd0, 12'd0, 16'd30000, 16'd10, 16'd5000);
    send_triplet('0, '0, SMP_MAX);
    send_triplet(SMP_MAX, 12'd3, '0);

    // Maximum dead time with the window end landing on it; zero gains add no step
    // to the previous duty.
    wait_drained();
    program_regs(8'd64, 8'd255, 8'd17, 16'd8190, 12'hFFF, 16'd0, 16'd0, 16'd0);
    send_triplet(12'd100, '0, SMP_MAX);
    send_triplet('0, SMP_MAX, 12'd100);

    // Random settings and traffic; advance through the idle mixes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      if (ph == 2) begin
        sender_idle_pct    = 49;
        receiver_idle_pct <= 28;
      end
      if (ph == 4) begin
        sender_idle_pct    = 0;
        receiver_idle_pct <= 0;
      end
      program_regs(8'(pick_reg(16'd255, 16'd255)), 8'(pick_reg(16'd255, 16'd255)),
                   8'(pick_reg(16'd255, 16'd255)), pick_reg(16'hFFFF, 16'hFFFF),
                   12'(pick_reg(16'd4095, 16'd4095)), pick_reg(16'hFFFF, 16'd20000),
                   pick_reg(16'hFFFF, 16'd50), pick_reg(16'hFFFF, 16'd20000));
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_triplet(pick_sample(), pick_sample(), pick_sample());
    end

    wait_drained();
    $display("Sent %0d sample triplets over %0d register settings, idling the sender",
             items_sent, settings_used);
    $display("and the receiver in turn, then neither, across clamp and gain corners.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("three_channel_led_current_pi_loop test passed");
    end else begin
      $display("three_channel_led_current_pi_loop test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lcpi_pkg.sv
rtl/lcpi_ctrl.sv
rtl/lcpi_lane.sv
rtl/lcpi_merge.sv
rtl/three_channel_led_current_pi_loop.sv
dv/led_pi_duty_checker.sv
dv/three_channel_led_current_pi_loop_test.sv
